// ===== design/unique_entry_deque_macros.svh =====
// assertion macros shared by the checker of the unique entry deque
// expects signals named clk and rst in the scope where a macro is used
`ifndef UNIQUE_ENTRY_DEQUE_MACROS_SVH
`define UNIQUE_ENTRY_DEQUE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define UED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define UED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ued_pkg.sv =====
// types and codes shared by the unique entry deque modules
// no dependencies
`default_nettype none

package ued_pkg;

  // command codes
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_CLEAR      = 3'd4;

  // status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;

  // field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned ID_W   = 10;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 11;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  // one result beat
  typedef struct packed {
    logic [OCC_W-1:0]  occupancy;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   popped_id;
  } result_t;

endpackage

`default_nettype wire

// ===== design/ued_out_reg.sv =====
// output register of the unique entry deque: holds one result beat until taken
// depends on ued_pkg
`default_nettype none

module ued_out_reg (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              load,
  input  wire  ued_pkg::result_t           res,
  output logic                             free,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // popped_id [9:0], status [11:10], occupancy [22:12], zero [23]
  output logic [ued_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import ued_pkg::*;

  result_t held;

  // room for a new beat when empty or when the current one leaves now
  assign free = !m_tvalid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, held};

endmodule

`default_nettype wire

// ===== design/unique_entry_deque.sv =====
// unique entry deque: double-ended queue of node ids that never holds an id twice
// depends on ued_pkg and ued_out_reg
//
// Usage:
//   s_tvalid/s_tready/s_tdata carries commands: push back, push front,
//   pop front, pop back, clear. Every command gives one result beat on
//   m_tvalid/m_tready/m_tdata with the popped id, a status and the occupancy.
//   Command and memory reads are registered on accept; the execute state
//   loads the result into the output register once it has room and writes
//   back the ring and membership memories before a new command is taken.
//   A result waiting in the output register does not block the next
//   command; only a second result with the register still full stalls.
//   Reset: pointers and count clear, then a sweep over every id slot zeroes
//   the membership memory while s_tready stays low.
//   A clear command answers at once and then runs the same membership
//   sweep before the next command is taken.
//   Pushing an id already queued (or outside the id space) reports a
//   duplicate; popping an empty queue reports empty and changes nothing.
`default_nettype none

module unique_entry_deque #(
  parameter int unsigned ID_SPACE = 1024
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // command [2:0], node_id [12:3], zero [15:13]
  input  wire  [ued_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // popped_id [9:0], status [11:10], occupancy [22:12], zero [23]
  output logic [ued_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import ued_pkg::*;

  localparam int unsigned PW = (ID_SPACE > 2) ? $clog2(ID_SPACE) : 1;
  localparam int unsigned CW = $clog2(ID_SPACE + 1);
  localparam int unsigned IW = (PW > ID_W) ? PW : ID_W;
  localparam int unsigned XW = (CW > OCC_W) ? CW : OCC_W;
  localparam logic [PW-1:0] LAST_SLOT = PW'(ID_SPACE - 1);

  typedef enum logic [2:0] {
    S_SWEEP = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state, state_next;

  // memories
  logic [ID_W-1:0] ring_mem [ID_SPACE];
  logic            mark_mem [ID_SPACE];

  logic [PW-1:0] head, head_next;
  logic [PW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [PW-1:0] sweep_idx;

  // registered command and memory read data
  logic [CMD_W-1:0] cmd_q;
  logic [ID_W-1:0]  id_q;
  logic             in_range_q;
  logic             mark_q;
  logic [ID_W-1:0]  ring_q;

  // write ports
  logic            ring_we;
  logic [PW-1:0]   ring_waddr;
  logic            mark_we;
  logic [PW-1:0]   mark_waddr;
  logic            mark_wdata;

  logic [CMD_W-1:0] in_cmd;
  logic [ID_W-1:0]  in_id;
  logic [IW-1:0]    in_id_wide;
  logic [IW-1:0]    id_q_wide;
  logic [IW-1:0]    popped_wide;
  logic [PW-1:0]    head_prev, tail_prev, head_inc, tail_inc;
  logic             accept, out_free, advance, popped_in_range;
  result_t          res;
  logic [ID_W-1:0]  res_id;
  logic [STAT_W-1:0] res_status;
  logic [XW-1:0]    count_wide;

  assign in_cmd     = s_tdata[CMD_W-1:0];
  assign in_id      = s_tdata[CMD_W +: ID_W];
  assign in_id_wide = IW'(in_id);
  assign id_q_wide  = IW'(id_q);
  assign popped_wide = IW'(ring_q);
  assign popped_in_range = 32'(ring_q) < 32'(ID_SPACE);

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign advance  = (state == S_EXEC) && out_free;

  // ring pointer neighbors
  assign head_inc  = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign tail_inc  = (tail == LAST_SLOT) ? '0 : tail + 1'b1;
  assign head_prev = (head == '0) ? LAST_SLOT : head - 1'b1;
  assign tail_prev = (tail == '0) ? LAST_SLOT : tail - 1'b1;

  // capture command and read both memories on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= in_cmd;
      id_q       <= in_id;
      in_range_q <= 32'(in_id) < 32'(ID_SPACE);
      mark_q     <= mark_mem[in_id_wide[PW-1:0]];
      ring_q     <= ring_mem[(in_cmd == CMD_POP_FRONT) ? head : tail_prev];
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= id_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
  end

  // next state, the sweep write, and in execute the result and the write-back
  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    ring_we    = 1'b0;
    ring_waddr = tail;
    mark_we    = 1'b0;
    mark_waddr = sweep_idx;
    mark_wdata = 1'b0;
    res_id     = '0;
    res_status = ST_DONE;
    case (state)
      S_SWEEP: begin
        mark_we = 1'b1;
        if (sweep_idx == LAST_SLOT) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_q)
          CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            if (!in_range_q || mark_q) begin
              res_status = ST_DUPLICATE;
            end else begin
              ring_we    = advance;
              mark_we    = advance;
              mark_waddr = id_q_wide[PW-1:0];
              mark_wdata = 1'b1;
              count_next = count + 1'b1;
              if (cmd_q == CMD_PUSH_BACK) begin
                ring_waddr = tail;
                tail_next  = tail_inc;
              end else begin
                ring_waddr = head_prev;
                head_next  = head_prev;
              end
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK: begin
            if (count == '0) begin
              res_status = ST_EMPTY;
            end else begin
              res_id     = ring_q;
              mark_we    = advance && popped_in_range;
              mark_waddr = popped_wide[PW-1:0];
              mark_wdata = 1'b0;
              count_next = count - 1'b1;
              if (cmd_q == CMD_POP_FRONT) begin
                head_next = head_inc;
              end else begin
                tail_next = tail_prev;
              end
            end
          end
          CMD_CLEAR: begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
          end
          default: begin
          end
        endcase
        if (advance) begin
          state_next = (cmd_q == CMD_CLEAR) ? S_SWEEP : S_IDLE;
        end
      end
      default: begin
        state_next = S_SWEEP;
      end
    endcase
  end

  // result beat assembly
  assign count_wide = XW'(count_next);
  assign res        = {count_wide[OCC_W-1:0], res_status, res_id};

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      sweep_idx <= '0;
    end else begin
      state <= state_next;
      if (advance) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
      if (state == S_SWEEP) begin
        sweep_idx <= (sweep_idx == LAST_SLOT) ? '0 : sweep_idx + 1'b1;
      end
    end
  end

  // result register
  ued_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

// ===== design/ued_checker.sv =====
// port-level checker for the unique entry deque and its bind
// depends on unique_entry_deque_macros.svh and ued_pkg
`default_nettype none

`include "unique_entry_deque_macros.svh"

module ued_checker #(
  parameter int unsigned ID_SPACE = 1024
) (
  input wire                              clk,
  input wire                              rst,
  input wire                              s_tvalid,
  input wire                              s_tready,
  input wire [ued_pkg::IN_TDATA_W-1:0]    s_tdata,
  input wire                              m_tvalid,
  input wire                              m_tready,
  input wire [ued_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import ued_pkg::*;

  logic [ID_W-1:0]   popped;
  logic [STAT_W-1:0] status;
  logic [OCC_W-1:0]  occ;

  assign popped = m_tdata[ID_W-1:0];
  assign status = m_tdata[ID_W +: STAT_W];
  assign occ    = m_tdata[ID_W + STAT_W +: OCC_W];

  // a stalled result beat holds
  `UED_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

  // a failed command never reports an id
  `UED_ASSERT_NOW(a_fail_no_id, m_tvalid && status != ST_DONE, popped == '0, "popped id set on failed command")

  // an empty pop sees an empty queue
  `UED_ASSERT_NOW(a_empty_occ, m_tvalid && status == ST_EMPTY, occ == '0, "empty pop with nonzero occupancy")

  // occupancy stays within the id space and the status is a known code
  `UED_ASSERT_NOW(a_occ_range, m_tvalid, 32'(occ) <= 32'(ID_SPACE) && status <= ST_EMPTY, "occupancy or status out of range")

  // the membership sweep keeps the command side closed right after reset
  `UED_ASSERT_NEXT(a_sweep_after_rst, 1'b1, !$fell(rst) || !s_tready, "command taken before the reset sweep")

endmodule

bind unique_entry_deque ued_checker #(.ID_SPACE(ID_SPACE)) u_ued_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
